FILE: rtl/dogc_pkg.sv
// dogc_pkg: shared types and constants of the degree ordered greedy colouring block
// no dependencies
`timescale 1ns / 1ps
package dogc_pkg;

   localparam int VERTEX_W = 7;
   localparam int COLOR_W  = 7;
   localparam int DEGREE_W = 8;
   localparam logic [DEGREE_W-1:0] DEGREE_MAX = 8'd255;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_RUN  = 1'b1;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LD_RDA,
      S_LD_WRA,
      S_LD_WRB,
      S_RUN,
      S_RK_RDV,
      S_RK_GETV,
      S_RK_RDW,
      S_RK_CMPW,
      S_RK_WRO,
      S_CL_RDO,
      S_CL_GETO,
      S_CL_RDA,
      S_CL_GETA,
      S_CL_RDC,
      S_CL_USEC,
      S_CL_FIND,
      S_CL_EMIT,
      S_CLEAR
   } state_type;

endpackage

FILE: rtl/dogc_if.sv
// dogc_req_if and dogc_rsp_if: valid/ready channels of the colouring block
// depends on dogc_pkg for field widths
`timescale 1ns / 1ps
interface dogc_req_if;
   logic                          valid;
   logic                          ready;
   logic                          command;
   logic [dogc_pkg::VERTEX_W-1:0] vertex_a;
   logic [dogc_pkg::VERTEX_W-1:0] vertex_b;
   modport source (output valid, command, vertex_a, vertex_b, input ready);
   modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

interface dogc_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [dogc_pkg::VERTEX_W-1:0] vertex;
   logic [dogc_pkg::COLOR_W-1:0]  color;
   logic                          last;
   modport source (output valid, vertex, color, last, input ready);
   modport sink   (input valid, vertex, color, last, output ready);
endinterface

FILE: rtl/degree_ordered_greedy_coloring.sv
// An edge load with an endpoint out of range is ignored; otherwise the first
// endpoint's adjacency and degree rows are read, modified and written, then the second's
// unless it is a self-loop; a run ranks every vertex, then colours the vertices in rank
// order, and it stalls while a result waits for ready.
// One transaction at a time; ready is low while a load or run is in progress.
// Synchronous reset sets the vertex count to MAX_VERTICES and clears all row valid bits (empty graph).
// depends on dogc_pkg, dogc_if, dogc_ram, dogc_rank_cmp
`timescale 1ns / 1ps
module degree_ordered_greedy_coloring #(
   parameter int MAX_VERTICES = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   dogc_req_if.sink                      req_chan,
   dogc_rsp_if.source                    rsp_chan,
   input  logic                          csr_wr_en,
   input  logic [dogc_pkg::VERTEX_W-1:0] csr_wr_data
);

   localparam int N  = MAX_VERTICES;
   localparam int IW = $clog2(N);
   localparam int VW = dogc_pkg::VERTEX_W;
   localparam int DW = dogc_pkg::DEGREE_W;
   localparam int CW = dogc_pkg::COLOR_W;
   localparam logic [VW-1:0] MAXV = VW'(N);

   dogc_pkg::state_type state_ff, state_in;

   logic [VW-1:0] cfg_ff;
   logic [IW-1:0] ia_ff, ia_in, ib_ff, ib_in;
   logic [IW-1:0] v_ff, v_in, w_ff, w_in, i_ff, i_in, k_ff, k_in, rank_ff, rank_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [DW-1:0] degv_ff, degv_in;
   logic [N-1:0]  row_ff, row_in, used_ff, used_in;
   logic [N-1:0]  row_valid_ff, row_valid_in, colored_ff, colored_in;
   logic [CW-1:0] col_ff, col_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_last_ff, rsp_last_in;
   logic [VW-1:0] rsp_vertex_ff, rsp_vertex_in;
   logic [CW-1:0] rsp_color_ff, rsp_color_in;

   logic [VW-1:0] n_eff, n_m1;
   logic [VW-1:0] va_m1, vb_m1;
   logic          edge_ok, precedes;

   // ram ports
   logic          adj_we, deg_we, ord_we, clr_we;
   logic [IW-1:0] adj_wa, adj_ra, deg_wa, deg_ra, ord_wa, ord_ra, clr_wa, clr_ra;
   logic [N-1:0]  adj_wd, adj_rd;
   logic [DW-1:0] deg_wd, deg_rd, deg_old, deg_w;
   logic [IW-1:0] ord_wd, ord_rd;
   logic [CW-1:0] clr_wd, clr_rd;
   logic [N-1:0]  adj_old;
   logic [DW:0]   deg_sum;

   dogc_ram #(.WIDTH(N), .DEPTH(N)) u_adj (
      .clock(clock), .wr_en(adj_we), .wr_addr(adj_wa), .wr_data(adj_wd),
      .rd_addr(adj_ra), .rd_data(adj_rd));
   dogc_ram #(.WIDTH(DW), .DEPTH(N)) u_deg (
      .clock(clock), .wr_en(deg_we), .wr_addr(deg_wa), .wr_data(deg_wd),
      .rd_addr(deg_ra), .rd_data(deg_rd));
   dogc_ram #(.WIDTH(IW), .DEPTH(N)) u_ord (
      .clock(clock), .wr_en(ord_we), .wr_addr(ord_wa), .wr_data(ord_wd),
      .rd_addr(ord_ra), .rd_data(ord_rd));
   dogc_ram #(.WIDTH(CW), .DEPTH(N)) u_clr (
      .clock(clock), .wr_en(clr_we), .wr_addr(clr_wa), .wr_data(clr_wd),
      .rd_addr(clr_ra), .rd_data(clr_rd));

   dogc_rank_cmp #(.IW(IW)) u_cmp (
      .deg_w(deg_w), .idx_w(w_ff), .deg_v(degv_ff), .idx_v(v_ff), .precedes(precedes));

   // effective vertex count and edge check
   assign n_eff   = (cfg_ff > MAXV) ? MAXV : cfg_ff;
   assign n_m1    = n_eff - VW'(1);
   assign va_m1   = req_chan.vertex_a - VW'(1);
   assign vb_m1   = req_chan.vertex_b - VW'(1);
   assign edge_ok = (req_chan.vertex_a != '0) && (req_chan.vertex_b != '0) &&
                    (req_chan.vertex_a <= n_eff) && (req_chan.vertex_b <= n_eff);

   // invalid rows read as zero
   assign deg_w = row_valid_ff[w_ff] ? deg_rd : '0;

   assign req_chan.ready  = (state_ff == dogc_pkg::S_IDLE);
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.vertex = rsp_vertex_ff;
   assign rsp_chan.color  = rsp_color_ff;
   assign rsp_chan.last   = rsp_last_ff;

   // state and control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dogc_pkg::S_IDLE;
         cfg_ff       <= MAXV;
         row_valid_ff <= '0;
         colored_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         row_valid_ff <= row_valid_in;
         colored_ff   <= colored_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cfg_ff <= csr_wr_data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      ia_ff         <= ia_in;
      ib_ff         <= ib_in;
      v_ff          <= v_in;
      w_ff          <= w_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      rank_ff       <= rank_in;
      idx_ff        <= idx_in;
      degv_ff       <= degv_in;
      row_ff        <= row_in;
      used_ff       <= used_in;
      col_ff        <= col_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_color_ff  <= rsp_color_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      ia_in         = ia_ff;
      ib_in         = ib_ff;
      v_in          = v_ff;
      w_in          = w_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      rank_in       = rank_ff;
      idx_in        = idx_ff;
      degv_in       = degv_ff;
      row_in        = row_ff;
      used_in       = used_ff;
      col_in        = col_ff;
      row_valid_in  = row_valid_ff;
      colored_in    = colored_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_color_in  = rsp_color_ff;
      rsp_last_in   = rsp_last_ff;
      adj_we = 1'b0; adj_wa = ia_ff; adj_wd = '0; adj_ra = '0;
      deg_we = 1'b0; deg_wa = ia_ff; deg_wd = '0; deg_ra = '0;
      ord_we = 1'b0; ord_wa = rank_ff; ord_wd = v_ff; ord_ra = i_ff;
      clr_we = 1'b0; clr_wa = idx_ff; clr_wd = col_ff; clr_ra = w_ff;
      adj_old = '0;
      deg_old = '0;
      deg_sum = '0;
      unique case (state_ff)
         dogc_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               if (req_chan.command == dogc_pkg::CMD_RUN) begin
                  state_in = dogc_pkg::S_RUN;
               end else if (edge_ok) begin
                  ia_in    = va_m1[IW-1:0];
                  ib_in    = vb_m1[IW-1:0];
                  state_in = dogc_pkg::S_LD_RDA;
               end
            end
         end
         dogc_pkg::S_LD_RDA: begin
            adj_ra   = ia_ff;
            deg_ra   = ia_ff;
            state_in = dogc_pkg::S_LD_WRA;
         end
         dogc_pkg::S_LD_WRA: begin
            // first endpoint update, read of second endpoint issued
            adj_old = row_valid_ff[ia_ff] ? adj_rd : '0;
            deg_old = row_valid_ff[ia_ff] ? deg_rd : '0;
            deg_sum = {1'b0, deg_old} + ((ia_ff == ib_ff) ? (DW+1)'(2) : (DW+1)'(1));
            adj_we  = 1'b1;
            adj_wa  = ia_ff;
            adj_wd  = adj_old | ({{(N-1){1'b0}}, 1'b1} << ib_ff);
            deg_we  = 1'b1;
            deg_wa  = ia_ff;
            deg_wd  = deg_sum[DW] ? dogc_pkg::DEGREE_MAX : deg_sum[DW-1:0];
            row_valid_in[ia_ff] = 1'b1;
            adj_ra  = ib_ff;
            deg_ra  = ib_ff;
            state_in = (ia_ff == ib_ff) ? dogc_pkg::S_IDLE : dogc_pkg::S_LD_WRB;
         end
         dogc_pkg::S_LD_WRB: begin
            adj_old = row_valid_ff[ib_ff] ? adj_rd : '0;
            deg_old = row_valid_ff[ib_ff] ? deg_rd : '0;
            deg_sum = {1'b0, deg_old} + (DW+1)'(1);
            adj_we  = 1'b1;
            adj_wa  = ib_ff;
            adj_wd  = adj_old | ({{(N-1){1'b0}}, 1'b1} << ia_ff);
            deg_we  = 1'b1;
            deg_wa  = ib_ff;
            deg_wd  = deg_sum[DW] ? dogc_pkg::DEGREE_MAX : deg_sum[DW-1:0];
            row_valid_in[ib_ff] = 1'b1;
            state_in = dogc_pkg::S_IDLE;
         end
         dogc_pkg::S_RUN: begin
            colored_in = '0;
            v_in       = '0;
            state_in   = (n_eff == '0) ? dogc_pkg::S_CLEAR : dogc_pkg::S_RK_RDV;
         end
         dogc_pkg::S_RK_RDV: begin
            deg_ra   = v_ff;
            state_in = dogc_pkg::S_RK_GETV;
         end
         dogc_pkg::S_RK_GETV: begin
            degv_in  = row_valid_ff[v_ff] ? deg_rd : '0;
            w_in     = '0;
            rank_in  = '0;
            state_in = dogc_pkg::S_RK_RDW;
         end
         dogc_pkg::S_RK_RDW: begin
            deg_ra   = w_ff;
            state_in = dogc_pkg::S_RK_CMPW;
         end
         dogc_pkg::S_RK_CMPW: begin
            // count the vertices that go before v
            if (precedes) begin
               rank_in = rank_ff + IW'(1);
            end
            w_in     = w_ff + IW'(1);
            state_in = (VW'(w_ff) == n_m1) ? dogc_pkg::S_RK_WRO : dogc_pkg::S_RK_RDW;
         end
         dogc_pkg::S_RK_WRO: begin
            ord_we = 1'b1;
            v_in   = v_ff + IW'(1);
            i_in   = '0;
            state_in = (VW'(v_ff) == n_m1) ? dogc_pkg::S_CL_RDO : dogc_pkg::S_RK_RDV;
         end
         dogc_pkg::S_CL_RDO: begin
            ord_ra   = i_ff;
            state_in = dogc_pkg::S_CL_GETO;
         end
         dogc_pkg::S_CL_GETO: begin
            idx_in   = ord_rd;
            state_in = dogc_pkg::S_CL_RDA;
         end
         dogc_pkg::S_CL_RDA: begin
            adj_ra   = idx_ff;
            state_in = dogc_pkg::S_CL_GETA;
         end
         dogc_pkg::S_CL_GETA: begin
            row_in   = row_valid_ff[idx_ff] ? adj_rd : '0;
            used_in  = '0;
            w_in     = '0;
            state_in = dogc_pkg::S_CL_RDC;
         end
         dogc_pkg::S_CL_RDC: begin
            clr_ra   = w_ff;
            state_in = dogc_pkg::S_CL_USEC;
         end
         dogc_pkg::S_CL_USEC: begin
            // mark colours held by coloured neighbours
            if (row_ff[w_ff] && colored_ff[w_ff]) begin
               used_in = used_ff | ({{(N-1){1'b0}}, 1'b1} << IW'(clr_rd - CW'(1)));
            end
            w_in     = w_ff + IW'(1);
            k_in     = '0;
            state_in = (VW'(w_ff) == n_m1) ? dogc_pkg::S_CL_FIND : dogc_pkg::S_CL_RDC;
         end
         dogc_pkg::S_CL_FIND: begin
            // step through the colour mask for the first free colour
            if (!used_ff[k_ff] || (k_ff == IW'(N - 1))) begin
               col_in   = CW'(k_ff) + CW'(1);
               state_in = dogc_pkg::S_CL_EMIT;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         dogc_pkg::S_CL_EMIT: begin
            if (!rsp_valid_ff) begin
               clr_we            = 1'b1;
               colored_in[idx_ff] = 1'b1;
               rsp_valid_in      = 1'b1;
               rsp_vertex_in     = VW'(idx_ff) + VW'(1);
               rsp_color_in      = col_ff;
               rsp_last_in       = (VW'(i_ff) == n_m1);
               i_in              = i_ff + IW'(1);
               state_in = (VW'(i_ff) == n_m1) ? dogc_pkg::S_CLEAR : dogc_pkg::S_CL_RDO;
            end
         end
         dogc_pkg::S_CLEAR: begin
            row_valid_in = '0;
            state_in     = dogc_pkg::S_IDLE;
         end
         default: begin
            state_in = dogc_pkg::S_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   // a pending result slot is filled on emit
   a_emit_fills: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dogc_pkg::S_CL_EMIT) && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("emit did not load the result register");

   // store is empty after a run
   a_clear_rows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dogc_pkg::S_CLEAR) |=> (row_valid_ff == '0))
      else $error("row valid bits not cleared after run");

   // a free colour always exists among the first n
   a_free_colour: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dogc_pkg::S_CL_FIND) |-> (used_ff != '1))
      else $error("colour mask full during search");

   // no new transaction taken in the run start state
   a_busy_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dogc_pkg::S_RUN) |-> !req_chan.ready)
      else $error("ready raised during a run");
`endif

endmodule

FILE: rtl/dogc_ram.sv
// dogc_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
module dogc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dogc_rank_cmp.sv
// dogc_rank_cmp: ordering compare, lower degree first, ties to lower index
// depends on dogc_pkg
`timescale 1ns / 1ps
module dogc_rank_cmp #(
   parameter int IW = 6
) (
   input  logic [dogc_pkg::DEGREE_W-1:0] deg_w,
   input  logic [IW-1:0]                 idx_w,
   input  logic [dogc_pkg::DEGREE_W-1:0] deg_v,
   input  logic [IW-1:0]                 idx_v,
   output logic                          precedes
);

   // w goes before v in visiting order
   assign precedes = (deg_w < deg_v) || ((deg_w == deg_v) && (idx_w < idx_v));

endmodule
